/* rtl/vspc_pkg.sv */
package vspc_pkg;

    localparam int POS_W    = 15;
    localparam int SOFT_W   = 10;
    localparam int PAT_W    = 16;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_MAX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_START_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_PATTERN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 2'd3;

    localparam logic [POS_W-1:0]  TRAVEL_MAX_RST     = 15'd1000;
    localparam logic [SOFT_W-1:0] SOFT_START_LEN_RST = 10'd200;
    localparam logic [PAT_W-1:0]  PHASE_PATTERN_RST  = 16'd19890;
    localparam logic [POS_W-1:0]  START_POSITION_RST = 15'd0;

    localparam logic signed [FRAC_W:0] FRAC_ONE = 17'sd16384;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [1:0]        phase;
        logic [3:0]        coil;
        logic [SOFT_W-1:0] soft_cnt;
        logic [1:0]        dir;
    } motion_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [1:0]        phase;
        logic [3:0]        coil;
        logic [SOFT_W-1:0] soft_cnt;
        logic              open_seen;
        logic              close_seen;
        logic              goto_seen;
    } ctrl_state_t;

    typedef struct packed {
        logic             open_req;
        logic             close_req;
        logic             goto_req;
        logic [POS_W-1:0] tgt;
        logic             range_error;
    } tick_in_t;

    typedef struct packed {
        logic              range_error;
        logic              target_reached;
        logic              busy_res;
        logic [1:0]        step_dir;
        logic [POS_W-1:0]  position;
        logic [3:0]        coils;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0]  travel_max;
        logic [SOFT_W-1:0] soft_start_len;
        logic [PAT_W-1:0]  phase_pattern;
    } cfg_t;

    function automatic motion_t soft_step(
        input motion_t          m,
        input logic             fwd,
        input logic [PAT_W-1:0] pattern,
        input logic [POS_W-1:0] limit
    );
        motion_t r;
        logic    do_step;
        r       = m;
        do_step = (m.soft_cnt == '0) || (m.soft_cnt[1:0] != 2'd0);
        if (m.soft_cnt != '0)
        begin
            r.soft_cnt = m.soft_cnt - 1'b1;
        end
        if (do_step)
        begin
            if (fwd)
            begin
                if (m.pos < limit)
                begin
                    r.phase = m.phase + 2'd1;
                    r.pos   = m.pos + 1'b1;
                    r.coil  = ~pattern[{r.phase, 2'b00} +: 4];
                    r.dir   = DIR_FWD;
                end
            end
            else
            begin
                if (m.pos != '0)
                begin
                    r.phase = m.phase - 2'd1;
                    r.pos   = m.pos - 1'b1;
                    r.coil  = ~pattern[{r.phase, 2'b00} +: 4];
                    r.dir   = DIR_BACK;
                end
            end
        end
        return r;
    endfunction

endpackage

/* rtl/vspc_tick.sv */
module vspc_tick
    import vspc_pkg::*;
(
    input  ctrl_state_t      st,
    input  tick_in_t         tin,
    input  cfg_t             cfg,
    input  logic [POS_W-1:0] limit,
    output ctrl_state_t      st_next,
    output result_t          res
);

    motion_t m;
    logic    o_seen;
    logic    c_seen;
    logic    g_seen;
    logic    stop;
    logic    busy;
    logic    reached;
    logic    rerr;

    always_comb
    begin
        m       = '{pos: st.pos, phase: st.phase, coil: st.coil, soft_cnt: st.soft_cnt,
                    dir: DIR_NONE};
        o_seen  = st.open_seen;
        c_seen  = st.close_seen;
        g_seen  = st.goto_seen;
        stop    = 1'b0;
        busy    = 1'b0;
        reached = 1'b0;
        rerr    = 1'b0;

        // a new request restarts the slow ramp
        if ((tin.open_req && !st.open_seen) || (tin.close_req && !st.close_seen)
            || (tin.goto_req && !st.goto_seen))
        begin
            m.soft_cnt = cfg.soft_start_len;
            o_seen = 1'b1;
            c_seen = 1'b1;
            g_seen = 1'b1;
        end

        if (tin.open_req)
        begin
            if (m.pos < cfg.travel_max)
            begin
                m = soft_step(m, 1'b1, cfg.phase_pattern, limit);
            end
            else
            begin
                busy = 1'b1;
                stop = 1'b1;
            end
        end
        else
        begin
            o_seen = 1'b0;
        end

        if (!stop)
        begin
            if (tin.close_req)
            begin
                if (m.pos != '0)
                begin
                    m = soft_step(m, 1'b0, cfg.phase_pattern, limit);
                end
                else
                begin
                    busy = 1'b1;
                    stop = 1'b1;
                end
            end
            else
            begin
                c_seen = 1'b0;
            end
        end

        if (!stop)
        begin
            if (tin.goto_req)
            begin
                rerr = tin.range_error;
                if (tin.tgt < m.pos)
                begin
                    m = soft_step(m, 1'b0, cfg.phase_pattern, limit);
                end
                else if (tin.tgt > m.pos)
                begin
                    m = soft_step(m, 1'b1, cfg.phase_pattern, limit);
                end
                else
                begin
                    reached = 1'b1;
                    g_seen  = 1'b0;
                end
                busy = 1'b1;
            end
            else
            begin
                g_seen = 1'b0;
            end
        end

        st_next.pos        = m.pos;
        st_next.phase      = m.phase;
        st_next.coil       = m.coil;
        st_next.soft_cnt   = m.soft_cnt;
        st_next.open_seen  = o_seen;
        st_next.close_seen = c_seen;
        st_next.goto_seen  = g_seen;

        res.coils          = m.coil;
        res.position       = m.pos;
        res.step_dir       = m.dir;
        res.busy_res       = busy;
        res.target_reached = reached;
        res.range_error    = rerr;
    end

endmodule

/* rtl/valve_stepper_position_controller.sv */
// channel   dir  beat fields (lsb first)
// s_axis    in   open_req, close_req, goto_req, target_frac (s16)
// m_axis    out  coils, position, step_dir, busy_res, target_reached, range_error
// cfg       in   write enable, register index, data (16 bit), no read-back
//
// two register stages: the target multiply feeds the input register, the
// position update feeds the output register; one beat per cycle while not stalled
// rst_n clears control state, restores config defaults and loads the reset start position
// m_tready low stalls the output register, then the input register, then s_tready
module valve_stepper_position_controller
    import vspc_pkg::*;
#(
    parameter int HARD_LIMIT = 30000
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // open_req, close_req, goto_req, target_frac[15:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // coils[3:0], position[14:0], step_dir[1:0],
                                            // busy_res, target_reached, range_error
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [POS_W-1:0] LIMIT = POS_W'(HARD_LIMIT);

    cfg_t        cfg_reg;
    ctrl_state_t st_reg;
    ctrl_state_t st_next;
    logic [POS_W-1:0] start_sat;

    // input stage
    logic             a_valid_reg;
    tick_in_t         a_reg;
    tick_in_t         a_next;
    logic signed [FRAC_W-1:0] frac;
    logic signed [FRAC_W:0]   frac_off;
    logic [FRAC_W-1:0]        off_u;
    logic [FRAC_W+POS_W-1:0]  prod;
    logic             in_range;

    // output stage
    logic             m_valid_reg;
    result_t          res;
    result_t          m_res_reg;

    logic             out_adv;
    logic             a_fire;
    logic             s_fire;

    assign out_adv  = !m_valid_reg || m_tready;
    assign a_fire   = a_valid_reg && out_adv;
    assign s_tready = !a_valid_reg || out_adv;
    assign s_fire   = s_tvalid && s_tready;

    assign frac     = s_tdata[FRAC_W+2:3];
    assign in_range = (frac <= 16'sd16384) && (frac >= -16'sd16384);
    assign frac_off = FRAC_W'(frac) + FRAC_ONE;
    assign off_u    = frac_off[FRAC_W-1:0];
    assign prod     = off_u * cfg_reg.travel_max;

    always_comb
    begin
        a_next.open_req    = s_tdata[0];
        a_next.close_req   = s_tdata[1];
        a_next.goto_req    = s_tdata[2];
        a_next.range_error = !in_range;
        a_next.tgt         = in_range ? prod[POS_W+14:15] : '0;
    end

    assign start_sat = (cfg_data[POS_W-1:0] > LIMIT) ? LIMIT : cfg_data[POS_W-1:0];

    vspc_tick u_tick (
        .st      (st_reg),
        .tin     (a_reg),
        .cfg     (cfg_reg),
        .limit   (LIMIT),
        .st_next (st_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.travel_max     <= TRAVEL_MAX_RST;
            cfg_reg.soft_start_len <= SOFT_START_LEN_RST;
            cfg_reg.phase_pattern  <= PHASE_PATTERN_RST;
            st_reg.pos             <= (START_POSITION_RST > LIMIT) ? LIMIT : START_POSITION_RST;
            st_reg.phase           <= '0;
            st_reg.coil            <= '0;
            st_reg.soft_cnt        <= '0;
            st_reg.open_seen       <= 1'b0;
            st_reg.close_seen      <= 1'b0;
            st_reg.goto_seen       <= 1'b0;
            a_valid_reg            <= 1'b0;
            m_valid_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_en)
            begin
                case (cfg_addr)
                    REG_TRAVEL_MAX:     cfg_reg.travel_max     <= cfg_data[POS_W-1:0];
                    REG_SOFT_START_LEN: cfg_reg.soft_start_len <= cfg_data[SOFT_W-1:0];
                    REG_PHASE_PATTERN:  cfg_reg.phase_pattern  <= cfg_data[PAT_W-1:0];
                    REG_START_POSITION: st_reg.pos             <= start_sat;
                    default: ;
                endcase
            end
            else if (a_fire)
            begin
                st_reg <= st_next;
            end

            if (s_tready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (out_adv)
            begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_reg <= a_next;
        end
        if (a_fire)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.range_error, m_res_reg.target_reached, m_res_reg.busy_res,
                       m_res_reg.step_dir, m_res_reg.position, m_res_reg.coils};

endmodule

/* rtl/vspc_checker.sv */
module vspc_checker
    import vspc_pkg::*;
#(
    parameter int HARD_LIMIT = 30000
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata
);

    localparam logic [POS_W-1:0] LIMIT = POS_W'(HARD_LIMIT);

    // output stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[20:19] != DIR_FWD + DIR_BACK)
        else $error("illegal step direction");

    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[18:4] <= LIMIT)
        else $error("position beyond hard limit");

    // goto flags only appear with busy set
    a_goto_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[22] || m_tdata[23]) |-> m_tdata[21])
        else $error("goto flag without busy");

endmodule

bind valve_stepper_position_controller vspc_checker #(.HARD_LIMIT(HARD_LIMIT)) u_vspc_checker (.*);
